>>> src/ssl_pkg.sv
// ----------------------------------------------------------------------------
// ssl_pkg
// Shared types, widths and constants for the slip-slope traction limiter.
// ----------------------------------------------------------------------------
package ssl_pkg;

	// Field widths.
	localparam int SLIP_W    = 16;
	localparam int TORQUE_W  = 16;
	localparam int SPEED_W   = 16;
	localparam int CFG_W     = 15;
	localparam int CFG_IDX_W = 2;
	localparam int FRAC_W    = 14;

	// Register indexes on the configuration channel.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENGAGE_SLIP      = 2'd0,
		REG_SLOPE_STEP_LIMIT = 2'd1,
		REG_REDUCE_GAIN      = 2'd2,
		REG_INCREASE_GAIN    = 2'd3
	} reg_idx_t;

	// Register reset values.
	localparam logic [CFG_W-1:0] RST_ENGAGE_SLIP      = 15'd2458;
	localparam logic [CFG_W-1:0] RST_SLOPE_STEP_LIMIT = 15'd16;
	localparam logic [CFG_W-1:0] RST_REDUCE_GAIN      = 15'd14746;
	localparam logic [CFG_W-1:0] RST_INCREASE_GAIN    = 15'd16712;

	// Launch tiers: speed bounds in cm/s and torque caps in 0.01 Nm.
	localparam logic signed [SPEED_W-1:0] SPEED_TIER1 = 16'sd100;
	localparam logic signed [SPEED_W-1:0] SPEED_TIER2 = 16'sd200;
	localparam logic signed [SPEED_W-1:0] SPEED_TIER3 = 16'sd400;
	localparam logic signed [SPEED_W-1:0] SPEED_TIER4 = 16'sd700;
	localparam logic [TORQUE_W-1:0] CAP_TIER1 = 16'd4108;
	localparam logic [TORQUE_W-1:0] CAP_TIER2 = 16'd10270;
	localparam logic [TORQUE_W-1:0] CAP_TIER3 = 16'd14378;
	localparam logic [TORQUE_W-1:0] CAP_TIER4 = 16'd18486;

	// Rounding offset for a product with a Q1.14 gain (half an LSB of the result).
	localparam logic [TORQUE_W+CFG_W:0] ROUND_HALF = 32'd8192;

	// Configuration register bank contents.
	typedef struct packed {
		logic [CFG_W-1:0] engage_slip;
		logic [CFG_W-1:0] slope_step_limit;
		logic [CFG_W-1:0] reduce_gain;
		logic [CFG_W-1:0] increase_gain;
	} cfg_t;

	// One control sample.
	typedef struct packed {
		logic signed [SLIP_W-1:0]  wheel_slip;
		logic [TORQUE_W-1:0]       torque_request;
		logic signed [SPEED_W-1:0] speed;
	} sample_t;

	// One result.
	typedef struct packed {
		logic [TORQUE_W-1:0] torque_out;
		logic                regulating;
		logic                launch_capped;
	} result_t;

endpackage

>>> src/ssl_if.sv
// ----------------------------------------------------------------------------
// ssl_if
// Valid/ready channel interfaces for samples, results and register writes.
// ----------------------------------------------------------------------------
interface ssl_sample_if;
	logic                              valid;
	logic                              ready;
	logic signed [ssl_pkg::SLIP_W-1:0]  wheel_slip;
	logic [ssl_pkg::TORQUE_W-1:0]       torque_request;
	logic signed [ssl_pkg::SPEED_W-1:0] speed;

	modport source (output valid, wheel_slip, torque_request, speed, input ready);
	modport sink (input valid, wheel_slip, torque_request, speed, output ready);
endinterface

interface ssl_result_if;
	logic                          valid;
	logic                          ready;
	logic [ssl_pkg::TORQUE_W-1:0]  torque_out;
	logic                          regulating;
	logic                          launch_capped;

	modport source (output valid, torque_out, regulating, launch_capped, input ready);
	modport sink (input valid, torque_out, regulating, launch_capped, output ready);
endinterface

interface ssl_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [ssl_pkg::CFG_IDX_W-1:0]  index;
	logic [ssl_pkg::CFG_W-1:0]      data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> src/ssl_cfg_regs.sv
// ----------------------------------------------------------------------------
// ssl_cfg_regs
// Configuration register bank, written over its own valid/ready channel.
// ----------------------------------------------------------------------------
module ssl_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	ssl_cfg_if.sink       cfg,
	output ssl_pkg::cfg_t regs
);

	ssl_pkg::cfg_t regs_q;

	// Writes are always taken.
	assign cfg.ready = 1'b1;

	// Register bank, reset to the documented defaults.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.engage_slip      <= ssl_pkg::RST_ENGAGE_SLIP;
			regs_q.slope_step_limit <= ssl_pkg::RST_SLOPE_STEP_LIMIT;
			regs_q.reduce_gain      <= ssl_pkg::RST_REDUCE_GAIN;
			regs_q.increase_gain    <= ssl_pkg::RST_INCREASE_GAIN;
		end else if (cfg.valid) begin
			case (ssl_pkg::reg_idx_t'(cfg.index))
				ssl_pkg::REG_ENGAGE_SLIP:      regs_q.engage_slip      <= cfg.data;
				ssl_pkg::REG_SLOPE_STEP_LIMIT: regs_q.slope_step_limit <= cfg.data;
				ssl_pkg::REG_REDUCE_GAIN:      regs_q.reduce_gain      <= cfg.data;
				ssl_pkg::REG_INCREASE_GAIN:    regs_q.increase_gain    <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	assign regs = regs_q;

endmodule

>>> src/ssl_core.sv
// ----------------------------------------------------------------------------
// ssl_core
// Limiter datapath and its state: launch tiers, slope test, gain scaling.
// ----------------------------------------------------------------------------
module ssl_core (
	input  logic             clk,
	input  logic             arst_n,
	input  ssl_pkg::cfg_t    regs,
	input  ssl_pkg::sample_t smp,
	input  logic             fire,
	output ssl_pkg::result_t res
);

	localparam int DIFF_W = ssl_pkg::SLIP_W + 1;
	localparam int REL_W  = ssl_pkg::SLIP_W + 3;
	localparam int PROD_W = ssl_pkg::TORQUE_W + ssl_pkg::CFG_W;
	localparam int SCL_W  = PROD_W + 1 - ssl_pkg::FRAC_W;

	logic signed [ssl_pkg::SLIP_W-1:0] last_slip_q;
	logic [ssl_pkg::TORQUE_W-1:0]      ceiling_q;
	logic                              engaged_q;

	logic                              launch;
	logic [ssl_pkg::TORQUE_W-1:0]      cap;
	logic signed [DIFF_W-1:0]          slip_x;
	logic signed [DIFF_W-1:0]          diff;
	logic signed [DIFF_W-1:0]          step_s;
	logic signed [DIFF_W-1:0]          thr_s;
	logic                              rising;
	logic                              falling;
	logic signed [REL_W-1:0]           slip5;
	logic signed [REL_W-1:0]           thr4;
	logic                              release_hit;
	logic [ssl_pkg::CFG_W-1:0]         gain;
	logic [PROD_W-1:0]                 prod;
	logic [PROD_W:0]                   rounded;
	logic [SCL_W-1:0]                  scaled;
	logic [SCL_W-1:0]                  ceil_sel;
	logic [ssl_pkg::TORQUE_W-1:0]      ceil_lim;
	logic [ssl_pkg::TORQUE_W-1:0]      ceiling_d;
	logic                              engaged_d;
	logic [ssl_pkg::TORQUE_W-1:0]      tq;

	// Launch tier selection on signed speed.
	always_comb begin
		launch = 1'b1;
		cap    = ssl_pkg::CAP_TIER1;
		if (smp.speed < ssl_pkg::SPEED_TIER1) begin
			cap = ssl_pkg::CAP_TIER1;
		end else if (smp.speed < ssl_pkg::SPEED_TIER2) begin
			cap = ssl_pkg::CAP_TIER2;
		end else if (smp.speed < ssl_pkg::SPEED_TIER3) begin
			cap = ssl_pkg::CAP_TIER3;
		end else if (smp.speed < ssl_pkg::SPEED_TIER4) begin
			cap = ssl_pkg::CAP_TIER4;
		end else begin
			launch = 1'b0;
		end
	end

	// Slope, activation and release comparisons, all exact.
	assign slip_x      = DIFF_W'(smp.wheel_slip);
	assign diff        = slip_x - DIFF_W'(last_slip_q);
	assign step_s      = signed'({2'b00, regs.slope_step_limit});
	assign thr_s       = signed'({2'b00, regs.engage_slip});
	assign rising      = diff > step_s;
	assign falling     = diff < -step_s;
	assign slip5       = REL_W'(smp.wheel_slip) + (REL_W'(smp.wheel_slip) <<< 2);
	assign thr4        = signed'({2'b00, regs.engage_slip, 2'b00});
	assign release_hit = slip5 < thr4;

	// Ceiling scaling: product with a Q1.14 gain rounded half up, then capped at the request.
	assign gain     = rising ? regs.reduce_gain : regs.increase_gain;
	assign prod     = PROD_W'(ceiling_q) * PROD_W'(gain);
	assign rounded  = {1'b0, prod} + ssl_pkg::ROUND_HALF;
	assign scaled   = rounded[PROD_W:ssl_pkg::FRAC_W];
	assign ceil_sel = (rising || falling) ? scaled : SCL_W'(ceiling_q);
	assign ceil_lim = (ceil_sel > SCL_W'(smp.torque_request)) ? smp.torque_request
		: ceil_sel[ssl_pkg::TORQUE_W-1:0];

	// Next state and output torque.
	always_comb begin
		engaged_d = engaged_q;
		ceiling_d = ceiling_q;
		tq        = smp.torque_request;
		if (launch) begin
			tq = (smp.torque_request < cap) ? smp.torque_request : cap;
		end else if (!engaged_q) begin
			ceiling_d = smp.torque_request;
			engaged_d = slip_x > thr_s;
		end else if (release_hit) begin
			engaged_d = 1'b0;
			ceiling_d = smp.torque_request;
		end else begin
			ceiling_d = ceil_lim;
			tq        = ceil_lim;
		end
	end

	// Controller state advances only on fired samples at or above the top launch speed bound.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_slip_q <= '0;
			ceiling_q   <= '0;
			engaged_q   <= 1'b0;
		end else if (fire && !launch) begin
			last_slip_q <= smp.wheel_slip;
			ceiling_q   <= ceiling_d;
			engaged_q   <= engaged_d;
		end
	end

	assign res.torque_out    = tq;
	assign res.regulating    = engaged_d;
	assign res.launch_capped = launch;

endmodule

>>> src/slip_slope_traction_limiter.sv
// ----------------------------------------------------------------------------
// slip_slope_traction_limiter
// Slip-slope traction control torque limiter, one control sample per cycle while the result channel is not stalled.
// ----------------------------------------------------------------------------
// Usage:
// Samples (slip ratio, torque request, speed) enter on the sample channel and
// one result (limited torque, regulating flag, launch flag) leaves on the
// result channel per sample, in order. The four gain and threshold registers
// are written on the cfg channel, which is always ready; write them only when
// no sample is in flight.
// A sample accepted into the input register passes through the core; its
// result is loaded into the output register when the output can advance and
// is then offered. One sample per cycle is sustained while the receiver takes
// results: the controller state (last slip, ceiling, engaged) is updated in
// the same cycle as the result is computed, so the next sample sees it.
// The critical path is the 16x15 ceiling multiply with its rounding and clamp.
// Reset clears the pipeline, the controller state and restores the register
// defaults. When the receiver stalls, the result is held in the output
// register, the input register fills, and sample.ready drops until it moves.
// ----------------------------------------------------------------------------
module slip_slope_traction_limiter (
	input  logic           clk,
	input  logic           arst_n,
	ssl_sample_if.sink     sample,
	ssl_result_if.source   result,
	ssl_cfg_if.sink        cfg
);

	ssl_pkg::cfg_t    regs;
	ssl_pkg::sample_t sample_s1;
	logic             valid_s1;
	ssl_pkg::result_t core_res;
	ssl_pkg::result_t result_q;
	logic             out_valid_q;
	logic             advance;
	logic             take;
	logic             fire;

	// Handshake control.
	assign advance      = !out_valid_q || result.ready;
	assign fire         = valid_s1 && advance;
	assign sample.ready = !valid_s1 || advance;
	assign take         = sample.valid && sample.ready;

	ssl_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	ssl_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.regs   (regs),
		.smp    (sample_s1),
		.fire   (fire),
		.res    (core_res)
	);

	// Valid bits of the input and output registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (take) begin
			sample_s1.wheel_slip     <= sample.wheel_slip;
			sample_s1.torque_request <= sample.torque_request;
			sample_s1.speed          <= sample.speed;
		end
		if (fire) begin
			result_q <= core_res;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.torque_out    = result_q.torque_out;
	assign result.regulating    = result_q.regulating;
	assign result.launch_capped = result_q.launch_capped;

endmodule

>>> src/ssl_checker.sv
// ----------------------------------------------------------------------------
// ssl_checker
// Port-level assertions for the traction limiter, bound to the top level.
// ----------------------------------------------------------------------------
module ssl_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [ssl_pkg::TORQUE_W-1:0] torque_out,
	input logic                         launch_capped
);

	// A pending result stays offered until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before transaction");

	// A stalled result keeps its torque.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(torque_out))
		else $error("stalled result changed");

	// An accepted sample is followed by an offered result once it has passed the input register.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ##1 out_valid)
		else $error("no result after accepted sample");

	// A launch-capped result never exceeds the highest tier cap.
	a_launch_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && launch_capped |-> torque_out <= ssl_pkg::CAP_TIER4)
		else $error("launch cap exceeded");

endmodule

bind slip_slope_traction_limiter ssl_checker u_ssl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (sample.valid),
	.in_ready      (sample.ready),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.torque_out    (result.torque_out),
	.launch_capped (result.launch_capped)
);
